### src/assert_macros.svh
// Assertion helper macros for the DRAM bank translation RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define DBAT_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define DBAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### src/dbat_pkg.sv
// Shared types, tables and helpers for DRAM bank address translation.
// No dependencies.
`timescale 1ns / 1ps

package dbat_pkg;

    localparam int NUM_BANKS = 2;
    localparam logic [3:0] MAX_LAYOUT = 4'd10;

    typedef enum logic [2:0] {
        BT_NONE  = 3'd0,
        BT_256K  = 3'd1,
        BT_256KI = 3'd2,
        BT_1M    = 3'd3,
        BT_1MI   = 3'd4,
        BT_4M    = 3'd5,
        BT_4MI   = 3'd6
    } t_btype;

    typedef enum logic [1:0] {
        K_PLAIN  = 2'd0,
        K_ILV    = 2'd1,
        K_4MI256 = 2'd2
    } t_kind;

    typedef t_btype [NUM_BANKS-1:0] t_bank_pair;

    function automatic logic [3:0] lay_code(input logic [3:0] lay);
        logic [3:0] c;
        case (lay)
            4'd0:    c = 4'h0;
            4'd1:    c = 4'h1;
            4'd2:    c = 4'h2;
            4'd3:    c = 4'h3;
            4'd4:    c = 4'hc;
            4'd5:    c = 4'h5;
            4'd6:    c = 4'hd;
            4'd7:    c = 4'h6;
            4'd8:    c = 4'h7;
            4'd9:    c = 4'he;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

    function automatic t_bank_pair lay_banks(input logic [3:0] lay);
        t_bank_pair p;
        case (lay)
            4'd0:    p = {BT_NONE,  BT_256K};
            4'd1:    p = {BT_NONE,  BT_256KI};
            4'd2:    p = {BT_256K,  BT_256KI};
            4'd3:    p = {BT_256KI, BT_256KI};
            4'd4:    p = {BT_1M,    BT_256KI};
            4'd5:    p = {BT_NONE,  BT_1MI};
            4'd6:    p = {BT_1MI,   BT_256KI};
            4'd7:    p = {BT_1M,    BT_1MI};
            4'd8:    p = {BT_1MI,   BT_1MI};
            4'd9:    p = {BT_4M,    BT_1MI};
            default: p = {BT_NONE,  BT_4MI};
        endcase
        return p;
    endfunction

    function automatic t_bank_pair map_banks(input logic [3:0] m);
        t_bank_pair p;
        case (m)
            4'd0:    p = {BT_NONE,  BT_256K};
            4'd1:    p = {BT_NONE,  BT_256KI};
            4'd2:    p = {BT_256K,  BT_256KI};
            4'd3:    p = {BT_256KI, BT_256KI};
            4'd4:    p = {BT_NONE,  BT_1M};
            4'd5:    p = {BT_NONE,  BT_1MI};
            4'd6:    p = {BT_1M,    BT_1MI};
            4'd7:    p = {BT_1MI,   BT_1MI};
            4'd8:    p = {BT_NONE,  BT_4M};
            4'd9:    p = {BT_NONE,  BT_4MI};
            4'd10:   p = {BT_4M,    BT_NONE};
            4'd11:   p = {BT_4MI,   BT_NONE};
            4'd12:   p = {BT_1M,    BT_256KI};
            4'd13:   p = {BT_1MI,   BT_256KI};
            4'd14:   p = {BT_4M,    BT_1MI};
            default: p = {BT_4MI,   BT_1MI};
        endcase
        return p;
    endfunction

    function automatic logic [24:0] type_size(input t_btype t);
        logic [24:0] s;
        case (t)
            BT_256K:  s = 25'h0080000;
            BT_256KI: s = 25'h0100000;
            BT_1M:    s = 25'h0200000;
            BT_1MI:   s = 25'h0400000;
            BT_4M:    s = 25'h0800000;
            BT_4MI:   s = 25'h1000000;
            default:  s = 25'h0000000;
        endcase
        return s;
    endfunction

    function automatic logic [10:0] type_mask(input t_btype t);
        logic [10:0] m;
        case (t)
            BT_256K, BT_256KI: m = 11'h1ff;
            BT_1M, BT_1MI:     m = 11'h3ff;
            BT_4M, BT_4MI:     m = 11'h7ff;
            default:           m = 11'h000;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] type_shift(input t_btype t);
        logic [3:0] s;
        case (t)
            BT_256K, BT_256KI: s = 4'd10;
            BT_1M, BT_1MI:     s = 4'd11;
            BT_4M, BT_4MI:     s = 4'd12;
            default:           s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

### src/dram_bank_address_translate.sv
// DRAM bank address translation, three-stage pipeline.
// Depends on dbat_pkg and assert_macros.svh.
//
// Input channel (i_valid/o_ready) carries one CPU access word: bank window
// and 24-bit byte address. Output channel (o_valid/i_ready) returns one word
// per access: physical DRAM address, hole flag and linear flag. A hole word
// has phys_addr 0; a linear word passes the CPU address through unchanged.
// Config channel (i_cfg_valid/o_cfg_ready, always ready) writes ram_layout
// (index 0) or ram_map (index 1); write only while the pipeline is empty.
// Stages, each a register set in this order: decode and base subtract,
// column/row assembly, physical base add; o_valid is the last valid bit.
// Throughput is one word per cycle while the receiver keeps i_ready high.
// Each stage has its own valid bit and loads when its successor can take
// its contents, so a stalled receiver fills the stages and then drops
// o_ready; nothing is lost or repeated. Reset clears the valid bits and
// both registers to 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dram_bank_address_translate
    import dbat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_bank_sel,
    input  logic [23:0] i_cpu_addr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [24:0] o_phys_addr,
    output logic        o_hole,
    output logic        o_linear
);

    logic [3:0] r_layout, r_map;

    // stage 1 registers
    logic        r_v1;
    logic [23:0] r_a1;
    logic [24:0] r_pbase1;
    logic [10:0] r_mask1;
    logic [3:0]  r_rps1, r_rvs1;
    logic        r_il1, r_hole1, r_lin1;
    t_kind       r_kind1;

    // stage 2 registers
    logic        r_v2;
    logic [23:0] r_p2;
    logic [24:0] r_pbase2;
    logic        r_hole2, r_lin2;

    // stage 3 (output) registers
    logic        r_v3;
    logic [24:0] r_phys3;
    logic        r_hole3, r_lin3;

    logic ready3, ready2, ready1;

    assign ready3  = !r_v3 || i_ready;
    assign ready2  = !r_v2 || ready3;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= '0;
            r_map    <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'b0) begin
                r_layout <= i_cfg_data;
            end else begin
                r_map <= i_cfg_data;
            end
        end
    end

    // ---- stage 1: table decode and virtual base subtract
    logic [3:0]  lay;
    t_bank_pair  lbanks, mbanks;
    t_btype      vt, pt;
    logic        lin, none;
    logic [24:0] vbase, pbase;
    t_kind       kind;
    logic        il;

    always_comb begin
        lay    = (r_layout > MAX_LAYOUT) ? MAX_LAYOUT : r_layout;
        lbanks = lay_banks(lay);
        mbanks = map_banks(r_map);
        vt     = mbanks[i_bank_sel];
        pt     = lbanks[i_bank_sel];
        lin    = (r_map == lay_code(lay));
        none   = (vt == BT_NONE) || (pt == BT_NONE);
        vbase  = i_bank_sel ? type_size(mbanks[0]) : 25'd0;
        pbase  = i_bank_sel ? type_size(lbanks[0]) : 25'd0;
        il     = (pt == BT_256KI) || (pt == BT_1MI) || (pt == BT_4MI);
        if (vt == BT_256K || vt == BT_1M || vt == BT_4M) begin
            kind = K_PLAIN;
        end else if (vt == BT_4MI && (pt == BT_256K || pt == BT_256KI)) begin
            kind = K_4MI256;
        end else begin
            kind = K_ILV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_a1     <= lin ? i_cpu_addr : (i_cpu_addr - vbase[23:0]);
            r_pbase1 <= pbase;
            r_mask1  <= type_mask(pt);
            r_rps1   <= type_shift(pt);
            r_rvs1   <= type_shift(vt);
            r_il1    <= il;
            r_kind1  <= kind;
            r_lin1   <= lin;
            r_hole1  <= !lin && none;
        end
    end

    // ---- stage 2: column / row assembly
    logic [23:0] a2, row_t, col_t, p;
    logic [10:0] row;
    logic [11:0] col;
    logic        odd_hole;

    always_comb begin
        a2       = {1'b0, r_a1[23:11], r_a1[9:0]};
        odd_hole = 1'b0;
        row      = '0;
        col      = '0;
        row_t    = '0;
        col_t    = '0;
        p        = '0;
        if (r_kind1 == K_PLAIN) begin
            col_t = (r_a1 >> 1) & {13'd0, r_mask1};
            row_t = (r_a1 >> r_rvs1) & {13'd0, r_mask1};
            col   = col_t[11:0];
            row   = row_t[10:0];
            p     = {23'd0, r_a1[0]} | ({12'd0, col} << 1) | ({13'd0, row} << r_rps1);
        end else if (!r_il1) begin
            odd_hole = r_a1[10];
            col_t    = (a2 >> 1) & {13'd0, r_mask1};
            if (r_kind1 == K_ILV) begin
                row_t = (a2 >> r_rvs1) & {13'd0, r_mask1};
            end else begin
                row_t = ((a2 & 24'h0ff000) >> 13) | (((a2 & 24'h200000) >> 22) << 9);
            end
            col = col_t[11:0];
            row = row_t[10:0];
            p   = {23'd0, r_a1[0]} | ({12'd0, col} << 1) | ({13'd0, row} << r_rps1);
        end else begin
            col_t = (r_a1 >> 1) & {12'd0, r_mask1, 1'b1};
            if (r_kind1 == K_ILV) begin
                row_t = (r_a1 >> (r_rvs1 + 4'd1)) & {13'd0, r_mask1};
            end else begin
                row_t = ((r_a1 & 24'h1fe000) >> 13) | ({23'd0, r_a1[22]} << 9);
            end
            col = col_t[11:0];
            row = row_t[10:0];
            p   = {23'd0, r_a1[0]} | ({12'd0, col} << 1)
                | ({13'd0, row} << (r_rps1 + 4'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_p2     <= r_lin1 ? r_a1 : p;
            r_pbase2 <= r_pbase1;
            r_lin2   <= r_lin1;
            r_hole2  <= r_hole1 || (!r_lin1 && odd_hole);
        end
    end

    // ---- stage 3: physical base add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (ready3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            if (r_hole2) begin
                r_phys3 <= '0;
            end else if (r_lin2) begin
                r_phys3 <= {1'b0, r_p2};
            end else begin
                r_phys3 <= {1'b0, r_p2} + r_pbase2;
            end
            r_hole3 <= r_hole2;
            r_lin3  <= r_lin2;
        end
    end

    assign o_valid     = r_v3;
    assign o_phys_addr = r_phys3;
    assign o_hole      = r_hole3;
    assign o_linear    = r_lin3;

    `DBAT_ASSERT(a_hole_not_linear, i_clk, i_rst_n, !(r_v3 && r_hole3 && r_lin3), "hole and linear both set")
    `DBAT_ASSERT_IMP(a_hole_zero, i_clk, i_rst_n, r_v3 && r_hole3, r_phys3 == 25'd0, "hole word with nonzero address")
    `DBAT_ASSERT_IMP(a_lin_narrow, i_clk, i_rst_n, r_v3 && r_lin3, !r_phys3[24], "linear word above 24 bits")

endmodule
